// File: sv/tssp_pkg.sv
// package for the tagged sensor sentence parser
// holds character codes, phase and result kind enums, state and result structs
// no dependencies
package tssp_pkg;

	localparam int FRAC_DIGITS_DEF = 3;
	localparam int FIFO_DEPTH = 4;

	localparam logic [30:0] MAG_MAX = 31'h7fff_ffff;
	localparam logic [4:0] FIELD_DROP = 5'd16;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_P = 8'h50;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_M = 8'h4d;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_Y = 8'h79;
	localparam logic [7:0] CH_Z = 8'h7a;

	localparam logic [4:0] FLD_C = 5'd0;
	localparam logic [4:0] FLD_P = 5'd1;
	localparam logic [4:0] FLD_R = 5'd2;
	localparam logic [4:0] FLD_T = 5'd3;
	localparam logic [4:0] FLD_M = 5'd4;
	localparam logic [4:0] FLD_G = 5'd8;
	localparam logic [4:0] FLD_A = 5'd12;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_TAG  = 2'd1,
		PH_AXIS = 2'd2,
		PH_NUM  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FIELD = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  field;
		logic [30:0] acc;
		logic        neg;
		logic        point;
		logic [2:0]  frac_cnt;
		logic        frozen;
		logic        started;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  field_id;
		logic [31:0] value;
		logic        last;
	} result_t;

	// results made by one character, r0 goes out first
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic [19:0] pow10(input logic [2:0] e);
		logic [19:0] p;
		case (e)
			3'd0: p = 20'd1;
			3'd1: p = 20'd10;
			3'd2: p = 20'd100;
			3'd3: p = 20'd1000;
			3'd4: p = 20'd10000;
			3'd5: p = 20'd100000;
			3'd6: p = 20'd1000000;
			default: p = 20'd1;
		endcase
		return p;
	endfunction

endpackage

// File: sv/tssp_parser.sv
// parser state register and per-character next-state and result logic
// depends on tssp_pkg
module tssp_parser #(
	parameter int FRAC_DIGITS = tssp_pkg::FRAC_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          ch,
	output tssp_pkg::push_t     push
);

	localparam logic [2:0] FRAC_LIM = 3'(FRAC_DIGITS);

	tssp_pkg::state_t st_q, st_nxt, num_in, tok;
	tssp_pkg::result_t r_field, r_tag;

	logic is_digit, is_sign, is_tok, is_axis, in_number, emit_field, tag_emits;
	logic [3:0]  digit;
	logic [34:0] acc_ext, acc10;
	logic [2:0]  scale;
	logic [50:0] prod;
	logic [30:0] mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		is_digit = ch inside {[tssp_pkg::CH_ZERO:tssp_pkg::CH_NINE]};
		is_sign = ch inside {tssp_pkg::CH_MINUS, tssp_pkg::CH_PLUS};
		is_tok = is_digit || is_sign || (ch == tssp_pkg::CH_DOT);
		is_axis = ch inside {tssp_pkg::CH_X, tssp_pkg::CH_Y, tssp_pkg::CH_Z};
		digit = 4'(ch - tssp_pkg::CH_ZERO);

		// a non-axis character after M, G or A starts the plain field's number
		num_in = st_q;
		if (st_q.phase == tssp_pkg::PH_AXIS) begin
			num_in = '0;
			num_in.phase = tssp_pkg::PH_NUM;
			num_in.field = st_q.field;
		end
		in_number = (st_q.phase == tssp_pkg::PH_NUM) ||
			((st_q.phase == tssp_pkg::PH_AXIS) && !is_axis);

		// take one token character
		acc_ext = {4'd0, num_in.acc};
		acc10 = (acc_ext << 3) + (acc_ext << 1) + {31'd0, digit};
		tok = num_in;
		tok.started = 1'b1;
		if (!num_in.frozen) begin
			if (is_sign) begin
				if (!num_in.started) begin
					tok.neg = (ch == tssp_pkg::CH_MINUS);
				end else begin
					tok.frozen = 1'b1;
				end
			end else if (ch == tssp_pkg::CH_DOT) begin
				if (num_in.point) begin
					tok.frozen = 1'b1;
				end else begin
					tok.point = 1'b1;
				end
			end else if (!(num_in.point && (num_in.frac_cnt >= FRAC_LIM))) begin
				if (num_in.point) begin
					tok.frac_cnt = num_in.frac_cnt + 3'd1;
				end
				tok.acc = (acc10 > 35'(tssp_pkg::MAG_MAX)) ? tssp_pkg::MAG_MAX : acc10[30:0];
			end
		end

		// finish: scale up to the full fraction, saturate, apply sign
		scale = FRAC_LIM - (num_in.point ? num_in.frac_cnt : 3'd0);
		prod = 51'(num_in.acc) * 51'(tssp_pkg::pow10(scale));
		mag = (prod > 51'(tssp_pkg::MAG_MAX)) ? tssp_pkg::MAG_MAX : prod[30:0];
		r_field.kind = tssp_pkg::KIND_FIELD;
		r_field.field_id = num_in.field[3:0];
		r_field.value = num_in.neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
		r_field.last = 1'b0;

		r_tag = '0;
		tag_emits = 1'b0;
		emit_field = 1'b0;
		st_nxt = st_q;

		if (st_q.phase == tssp_pkg::PH_HUNT) begin
			if (ch == tssp_pkg::CH_DOLLAR) begin
				st_nxt.phase = tssp_pkg::PH_TAG;
			end
		end else if ((st_q.phase == tssp_pkg::PH_AXIS) && is_axis) begin
			st_nxt = '0;
			st_nxt.phase = tssp_pkg::PH_NUM;
			st_nxt.field = st_q.field + 5'd1 + 5'(ch - tssp_pkg::CH_X);
		end else if (in_number && is_tok) begin
			st_nxt = tok;
		end else begin
			// this character is a tag, possibly closing a number first
			st_nxt = num_in;
			emit_field = in_number && (num_in.field != tssp_pkg::FIELD_DROP);
			case (ch)
				tssp_pkg::CH_C, tssp_pkg::CH_P, tssp_pkg::CH_R, tssp_pkg::CH_T,
				tssp_pkg::CH_D: begin
					st_nxt = '0;
					st_nxt.phase = tssp_pkg::PH_NUM;
					case (ch)
						tssp_pkg::CH_C: st_nxt.field = tssp_pkg::FLD_C;
						tssp_pkg::CH_P: st_nxt.field = tssp_pkg::FLD_P;
						tssp_pkg::CH_R: st_nxt.field = tssp_pkg::FLD_R;
						tssp_pkg::CH_T: st_nxt.field = tssp_pkg::FLD_T;
						default: st_nxt.field = tssp_pkg::FIELD_DROP;
					endcase
				end
				tssp_pkg::CH_M: begin
					st_nxt.phase = tssp_pkg::PH_AXIS;
					st_nxt.field = tssp_pkg::FLD_M;
				end
				tssp_pkg::CH_G: begin
					st_nxt.phase = tssp_pkg::PH_AXIS;
					st_nxt.field = tssp_pkg::FLD_G;
				end
				tssp_pkg::CH_A: begin
					st_nxt.phase = tssp_pkg::PH_AXIS;
					st_nxt.field = tssp_pkg::FLD_A;
				end
				tssp_pkg::CH_STAR: begin
					tag_emits = 1'b1;
					r_tag.kind = tssp_pkg::KIND_END;
					st_nxt.phase = tssp_pkg::PH_HUNT;
				end
				tssp_pkg::CH_DOLLAR: begin
					tag_emits = 1'b1;
					r_tag.kind = tssp_pkg::KIND_END;
					st_nxt.phase = tssp_pkg::PH_TAG;
				end
				default: begin
					tag_emits = 1'b1;
					r_tag.kind = tssp_pkg::KIND_ERR;
					st_nxt.phase = tssp_pkg::PH_HUNT;
				end
			endcase
		end

		r_tag.last = 1'b1;
		r_field.last = !tag_emits;
		push.r1 = r_tag;
		if (emit_field) begin
			push.r0 = r_field;
			push.n = tag_emits ? 2'd2 : 2'd1;
		end else begin
			push.r0 = r_tag;
			push.n = tag_emits ? 2'd1 : 2'd0;
		end
	end

endmodule

// File: sv/tssp_out_fifo.sv
// result queue: takes up to two results per cycle, hands out one per transfer
// depends on tssp_pkg
module tssp_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  tssp_pkg::push_t     push,
	input  logic                pop,
	output tssp_pkg::result_t   head,
	output logic [2:0]          level
);

	tssp_pkg::result_t mem_q [tssp_pkg::FIFO_DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] level_q;
	logic [1:0] n_in;

	assign n_in = push_en ? push.n : 2'd0;
	assign head = mem_q[rd_ptr_q];
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (n_in == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_in;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			level_q <= level_q + {1'b0, n_in} - {2'd0, pop};
		end
	end

endmodule

// File: sv/tagged_sensor_sentence_parser.sv
// top level of the tagged sensor sentence parser
// instantiates tssp_parser and tssp_out_fifo, uses tssp_pkg
//
// Streaming parser for sensor sentences, one character per input transfer.
// Characters are skipped until '$'; then tags C, P, R, T, D and M, G, A (with
// optional axis x, y, z) are read, each followed by a signed decimal number.
// A number is reported when the next tag or '*' arrives, as value times
// 10^FRAC_DIGITS, truncated and saturated to +/-2147483647; D is parsed but
// never reported. A character makes zero, one or two results; last_of_item
// marks the final one. Throughput is one character per clock while the
// queue has room: a character is registered, decoded combinationally by
// the parser (the multiply-by-ten and scale multiply set the path), and
// its results enter a four-entry result queue. The parser only advances
// while the queue holds at most two results, so a stalled output side
// backs up into char_in after the queue and the input register fill.
module tagged_sensor_sentence_parser #(
	parameter int FRAC_DIGITS = tssp_pkg::FRAC_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         result_kind,
	output logic [3:0]         field_id,
	output logic signed [31:0] field_value,
	output logic               last_of_item
);

	logic [7:0] char_s1;
	logic       valid_s1;
	logic       room;
	logic       fire;
	logic       pop;
	logic [2:0] level;
	tssp_pkg::push_t   push;
	tssp_pkg::result_t head;

	// the queue can always absorb two results while it holds two or fewer
	assign room = (level <= 3'd2);
	assign fire = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// input register, refilled in the same cycle it is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	tssp_parser #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (char_s1),
		.push   (push)
	);

	// result queue drives the output channel directly
	assign out_valid = (level != 3'd0);
	assign pop = out_valid && out_ready;

	tssp_out_fifo u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_en (fire),
		.push    (push),
		.pop     (pop),
		.head    (head),
		.level   (level)
	);

	assign result_kind = head.kind;
	assign field_id = head.field_id;
	assign field_value = head.value;
	assign last_of_item = head.last;

	// end and error results always close their character's burst
	a_tag_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != tssp_pkg::KIND_FIELD) |-> last_of_item)
		else $error("end or error result without last_of_item");

	// end and error results carry zero id and value
	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != tssp_pkg::KIND_FIELD) |->
		(field_id == 4'd0) && (field_value == 32'sd0))
		else $error("end or error result with nonzero payload");

	// a pair of results always leads with the closed field
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (push.n == 2'd2) |->
		(push.r0.kind == tssp_pkg::KIND_FIELD) && !push.r0.last && push.r1.last)
		else $error("two results in wrong order");

	// queue never overflows
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'(tssp_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	// a character that makes results shows one on the next cycle
	a_result_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (push.n != 2'd0) |=> out_valid)
		else $error("pushed result not visible");

endmodule
